// ===== rtl/srrw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared constants and controller/datapath interface types for the
// selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

	localparam int DEFAULT_WINDOW_SLOTS = 16;
	localparam int SEQ_W                = 32;
	localparam int RELEASED_W           = 9;

	typedef struct packed {
		logic capture;
		logic eval;
		logic walk;
	} srrw_cmd_t;

	typedef struct packed {
		logic start_walk;
		logic walk_more;
		logic out_busy;
	} srrw_status_t;

endpackage

// ===== rtl/srrw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_ctrl
// Sequencer for the receive window: capture, evaluate, release walk.
// ----------------------------------------------------------------------------
module srrw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  srrw_pkg::srrw_status_t status,
	output srrw_pkg::srrw_cmd_t    cmd
);
	import srrw_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WALK
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.capture = in_valid && !status.out_busy;
			ST_EVAL: cmd.eval    = 1'b1;
			ST_WALK: cmd.walk    = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE) || status.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= status.start_walk ? ST_WALK : ST_IDLE;
				end
				ST_WALK: begin
					if (!status.walk_more) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/srrw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_datapath
// Received map, expected sequence number, release walk and result register.
// ----------------------------------------------------------------------------
module srrw_datapath #(
	parameter int WINDOW_SLOTS = srrw_pkg::DEFAULT_WINDOW_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srrw_pkg::srrw_cmd_t               cmd,
	output srrw_pkg::srrw_status_t            status,
	input  logic [srrw_pkg::SEQ_W-1:0]        seq_num,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              send_ack,
	output logic [srrw_pkg::SEQ_W-1:0]        ack_num,
	output logic [srrw_pkg::RELEASED_W-1:0]   released_count,
	output logic [srrw_pkg::SEQ_W-1:0]        next_expected
);
	import srrw_pkg::*;

	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);

	logic [WINDOW_SLOTS-1:0] map_q;
	logic [SEQ_W-1:0]        expected_q;
	logic [SLOT_W-1:0]       exp_slot_q;
	logic [SEQ_W-1:0]        seq_q;
	logic [SEQ_W-1:0]        cur_q;
	logic [SLOT_W-1:0]       cur_slot_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;

	logic [SEQ_W-1:0]  offset;
	logic              in_window;
	logic              wrapped;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] seq_slot;
	logic [SLOT_W-1:0] cur_slot_next;
	logic              load_out;

	assign offset    = seq_q - expected_q;
	assign in_window = offset < SEQ_W'(WINDOW_SLOTS);
	assign wrapped   = seq_q < expected_q;
	assign slot_sum  = {1'b0, exp_slot_q} + offset[SLOT_W:0];

	always_comb begin
		if (wrapped) begin
			seq_slot = seq_q[SLOT_W-1:0];
		end else if (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS)) begin
			seq_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_SLOTS));
		end else begin
			seq_slot = slot_sum[SLOT_W-1:0];
		end
	end

	always_comb begin
		if (cur_q == '1) begin
			cur_slot_next = '0;
		end else if (cur_slot_q == SLOT_W'(WINDOW_SLOTS - 1)) begin
			cur_slot_next = '0;
		end else begin
			cur_slot_next = cur_slot_q + 1'b1;
		end
	end

	assign status.start_walk = in_window && (seq_q == expected_q);
	assign status.walk_more  = (cnt_q < CNT_W'(WINDOW_SLOTS)) && map_q[cur_slot_q];
	assign status.out_busy   = out_valid_q && out_stall;

	assign load_out = (cmd.eval && !status.start_walk) || (cmd.walk && !status.walk_more);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= '0;
			expected_q  <= '0;
			exp_slot_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.eval && in_window) begin
				map_q[seq_slot] <= 1'b1;
			end
			if (cmd.walk && status.walk_more) begin
				map_q[cur_slot_q] <= 1'b0;
			end
			if (cmd.walk && !status.walk_more) begin
				expected_q <= cur_q;
				exp_slot_q <= cur_slot_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_q <= seq_num;
		end
		if (cmd.eval) begin
			cur_q      <= expected_q;
			cur_slot_q <= exp_slot_q;
			cnt_q      <= '0;
		end else if (cmd.walk && status.walk_more) begin
			cur_q      <= cur_q + 1'b1;
			cur_slot_q <= cur_slot_next;
			cnt_q      <= cnt_q + 1'b1;
		end
		if (cmd.eval && !status.start_walk) begin
			send_ack       <= in_window;
			ack_num        <= seq_q;
			released_count <= '0;
			next_expected  <= expected_q;
		end else if (cmd.walk && !status.walk_more) begin
			send_ack       <= 1'b1;
			ack_num        <= seq_q;
			released_count <= RELEASED_W'(cnt_q);
			next_expected  <= cur_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/selective_repeat_receive_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver side of a selective-repeat sliding window over 32-bit sequence
// numbers, with a received-slot map and in-order release.
// ----------------------------------------------------------------------------
// The input channel transfers one packet sequence number per item. Each item
// produces exactly one result transfer with the acknowledge flag, the
// acknowledged number, the count of packets released in order and the next
// expected sequence number.
// An item is captured in one cycle and evaluated in the next. An item that
// releases nothing returns to idle after evaluation; no new item is taken
// until the previous one is finished. An item equal to the next expected
// number walks the received map one slot per cycle, then loads its result.
// The result sits in an output register; the next item can be taken in the same
// cycle that the previous result is transferred.
// Reset clears the received map and sets the expected number to zero; the
// block is ready as soon as reset is released.
// While the receiver stalls a waiting result, the result holds and no new
// item is taken.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
	parameter int WINDOW_SLOTS = srrw_pkg::DEFAULT_WINDOW_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [srrw_pkg::SEQ_W-1:0]        seq_num,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              send_ack,
	output logic [srrw_pkg::SEQ_W-1:0]        ack_num,
	output logic [srrw_pkg::RELEASED_W-1:0]   released_count,
	output logic [srrw_pkg::SEQ_W-1:0]        next_expected
);
	import srrw_pkg::*;

	srrw_cmd_t    cmd;
	srrw_status_t status;

	srrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	srrw_datapath #(
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.seq_num        (seq_num),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.send_ack       (send_ack),
		.ack_num        (ack_num),
		.released_count (released_count),
		.next_expected  (next_expected)
	);

endmodule

// ===== rtl/srrw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_checker
// Port-level checks for the selective-repeat receive window.
// ----------------------------------------------------------------------------
module srrw_checker #(
	parameter int WINDOW_SLOTS = srrw_pkg::DEFAULT_WINDOW_SLOTS
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              send_ack,
	input logic [srrw_pkg::SEQ_W-1:0]        ack_num,
	input logic [srrw_pkg::RELEASED_W-1:0]   released_count,
	input logic [srrw_pkg::SEQ_W-1:0]        next_expected
);
	import srrw_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ack_num) &&
		$stable(released_count) && $stable(next_expected) && $stable(send_ack))
		else $error("Stalled result changed.");

	a_drop_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_ack |-> released_count == '0)
		else $error("Dropped packet released data.");

	a_release_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && released_count != '0 |->
		next_expected == ack_num + SEQ_W'(released_count))
		else $error("Expected number does not follow the release.");

	a_release_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> released_count <= RELEASED_W'(WINDOW_SLOTS))
		else $error("Release count exceeds window.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Second item taken before the first finished.");

endmodule

bind selective_repeat_receive_window srrw_checker #(
	.WINDOW_SLOTS (WINDOW_SLOTS)
) u_srrw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.send_ack       (send_ack),
	.ack_num        (ack_num),
	.released_count (released_count),
	.next_expected  (next_expected)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the selective-repeat receive window. Packet
// sequence numbers are sent through the input channel while a predictor
// keeps its own copy of the received map and the next expected number; each
// result transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	import srrw_pkg::*;

	localparam int WINDOW_SLOTS = DEFAULT_WINDOW_SLOTS;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 25;
	localparam int MAX_PRINTED  = 40;

	typedef struct packed {
		logic                  send_ack;
		logic [SEQ_W-1:0]      ack_num;
		logic [RELEASED_W-1:0] released_count;
		logic [SEQ_W-1:0]      next_expected;
	} window_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [SEQ_W-1:0]      seq_num;
	logic                  out_valid;
	logic                  out_stall;
	logic                  send_ack;
	logic [SEQ_W-1:0]      ack_num;
	logic [RELEASED_W-1:0] released_count;
	logic [SEQ_W-1:0]      next_expected;

	bit               slot_seen [WINDOW_SLOTS];
	logic [SEQ_W-1:0] window_base;
	window_result_t   pending_acks [$];
	window_result_t   ack_want;

	int error_count;
	int send_gap_pct;
	int recv_stall_pct;
	int stall_hold_req;
	int stall_hold_left;
	int quiet_cycles;

	selective_repeat_receive_window #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.seq_num       (seq_num),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.send_ack      (send_ack),
		.ack_num       (ack_num),
		.released_count(released_count),
		.next_expected (next_expected)
	);

	always #2 clk = ~clk;

	function automatic window_result_t window_predict(input logic [SEQ_W-1:0] s);
		window_result_t   r;
		logic [SEQ_W-1:0] offset;
		logic [SEQ_W-1:0] cur;
		int unsigned      count;
		r = '0;
		r.ack_num = s;
		offset = s - window_base;
		count = 0;
		if (offset < WINDOW_SLOTS) begin
			r.send_ack = 1'b1;
			slot_seen[s % WINDOW_SLOTS] = 1'b1;
			if (s == window_base) begin
				cur = window_base;
				while (count < WINDOW_SLOTS && slot_seen[cur % WINDOW_SLOTS]) begin
					slot_seen[cur % WINDOW_SLOTS] = 1'b0;
					cur = cur + 1;
					count++;
				end
				window_base = cur;
			end
		end
		r.released_count = RELEASED_W'(count);
		r.next_expected = window_base;
		return r;
	endfunction

	function automatic logic [SEQ_W-1:0] pick_seq();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return window_base;
		else if (roll < 75)
			return window_base + $urandom_range(WINDOW_SLOTS - 1, 1);
		else if (roll < 82)
			return window_base + WINDOW_SLOTS + $urandom_range(31);
		else if (roll < 88)
			return window_base - 1 - $urandom_range(31);
		else
			return $urandom();
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic send_seq(input logic [SEQ_W-1:0] s);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		seq_num <= s;
		do @(posedge clk); while (in_stall);
		pending_acks.push_back(window_predict(s));
	endtask

	// Result side: checks every transfer and drives the stall.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_acks.size() == 0) begin
				report_mismatch($sformatf("result for seq %0h with nothing outstanding", ack_num));
			end else begin
				ack_want = pending_acks.pop_front();
				if (send_ack !== ack_want.send_ack)
					report_mismatch($sformatf("seq %0h: send_ack %0b, expected %0b",
						ack_want.ack_num, send_ack, ack_want.send_ack));
				if (ack_num !== ack_want.ack_num)
					report_mismatch($sformatf("ack_num %0h, expected %0h",
						ack_num, ack_want.ack_num));
				if (released_count !== ack_want.released_count)
					report_mismatch($sformatf("seq %0h: released_count %0d, expected %0d",
						ack_want.ack_num, released_count, ack_want.released_count));
				if (next_expected !== ack_want.next_expected)
					report_mismatch($sformatf("seq %0h: next_expected %0h, expected %0h",
						ack_want.ack_num, next_expected, ack_want.next_expected));
			end
		end
		if (stall_hold_req != 0) begin
			stall_hold_left = stall_hold_req;
			stall_hold_req = 0;
		end
		if (stall_hold_left > 0) begin
			out_stall <= 1'b1;
			stall_hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic test_in_order();
		send_seq(32'h0000_0000);
		send_seq(32'h0000_0001);
	endtask

	task automatic test_out_of_window();
		send_seq(32'hFFFF_FFFF);
		send_seq(window_base + WINDOW_SLOTS);
		send_seq(window_base - 1);
	endtask

	task automatic test_reorder_duplicate();
		logic [SEQ_W-1:0] b;
		b = window_base;
		send_seq(b + WINDOW_SLOTS - 1);
		send_seq(b + WINDOW_SLOTS - 1);
		send_seq(b + 2);
		send_seq(b + 1);
		send_seq(b);
	endtask

	task automatic test_full_window();
		logic [SEQ_W-1:0] b;
		b = window_base;
		for (int i = 1; i < WINDOW_SLOTS; i++)
			send_seq(b + i);
		send_seq(b);
	endtask

	task automatic test_random(input int count);
		repeat (count) send_seq(pick_seq());
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_backpressure();
		int saved_gap;
		saved_gap = send_gap_pct;
		send_gap_pct = 0;
		stall_hold_req = 300;
		repeat (24) send_seq(pick_seq());
		send_gap_pct = saved_gap;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		seq_num = '0;
		out_stall = 1'b0;
		error_count = 0;
		stall_hold_req = 0;
		stall_hold_left = 0;
		quiet_cycles = 0;
		window_base = '0;
		foreach (slot_seen[i]) slot_seen[i] = 1'b0;
		send_gap_pct = 36;
		recv_stall_pct = 83;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_in_order();
		test_out_of_window();
		test_reorder_duplicate();
		test_full_window();
		test_random(225);

		send_gap_pct = 83;
		recv_stall_pct = 36;
		test_random(225);
		test_backpressure();

		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random(200);

		in_valid <= 1'b0;
		while (pending_acks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/srrw_pkg.sv
rtl/srrw_ctrl.sv
rtl/srrw_datapath.sv
rtl/selective_repeat_receive_window.sv
rtl/srrw_checker.sv
verif/testbench.sv
